// ----- hdl/rwlm_pkg.sv -----
package rwlm_pkg;

   localparam int NUM_LOCKS   = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_BITS    = 8;

   localparam int ACTION_W = 2;
   localparam int LOCK_W   = 4;
   localparam int REQ_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;
   localparam int CFG_W    = 5;

   localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = HEAD_W + 1;
   localparam int ENTRY_W = TAG_BITS + 1;
   localparam int STORE_DEPTH = NUM_LOCKS * QUEUE_DEPTH;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_RD_LOCK   = 2'd0,
      ACT_RD_UNLOCK = 2'd1,
      ACT_WR_LOCK   = 2'd2,
      ACT_WR_UNLOCK = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_RELEASED = 3'd2,
      ST_WOKEN    = 3'd3,
      ST_BAD_LOCK = 3'd4,
      ST_NOT_HELD = 3'd5,
      ST_FULL     = 3'd6
   } status_type;

endpackage

// ----- hdl/rwlm_req_if.sv -----
interface rwlm_req_if import rwlm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACTION_W-1:0] action;
   logic [LOCK_W-1:0] lock_id;
   logic [REQ_W-1:0]  requester;

   modport source (output valid, action, lock_id, requester, input ready);
   modport sink   (input valid, action, lock_id, requester, output ready);
endinterface

// ----- hdl/rwlm_rsp_if.sv -----
interface rwlm_rsp_if import rwlm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LOCK_W-1:0]   result_lock;
   logic [REQ_W-1:0]    result_tag;
   logic                waiter_is_writer;
   logic [COUNT_W-1:0]  readers_now;
   logic                busy_now;
   logic                last;

   modport source (output valid, status, result_lock, result_tag, waiter_is_writer,
                   readers_now, busy_now, last, input ready);
   modport sink   (input valid, status, result_lock, result_tag, waiter_is_writer,
                   readers_now, busy_now, last, output ready);
endinterface

// ----- hdl/reader_writer_lock_manager_top.sv -----
// Reader-writer lock manager for 16 locks, each with an 8-deep FIFO of waiters.
// A request is registered on entry and then resolved from that register against
// the per-lock reader count, busy flag and queue pointers, which sit in
// flip-flops; the waiter queues share one RAM. Requests that give one result
// stream through the resolve stage at one per cycle while the result side
// keeps up. An unlock that wakes a waiter gives two results: the release, then
// the woken waiter read from the waiter RAM, and holds the resolve stage until
// the waiter's result is registered. No clearing pass is needed after reset.
module reader_writer_lock_manager_top import rwlm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   rwlm_req_if.sink         req_chan,
   rwlm_rsp_if.source       rsp_chan
);

   logic [CFG_W-1:0] locks_ff;

   logic [COUNT_W-1:0] rc_ff   [NUM_LOCKS];
   logic               busy_ff [NUM_LOCKS];
   logic [HEAD_W-1:0]  head_ff [NUM_LOCKS];
   logic [FILL_W-1:0]  fill_ff [NUM_LOCKS];

   logic              in_vld_ff;
   action_type        in_act_ff;
   logic [LOCK_W-1:0] in_lock_ff;
   logic [REQ_W-1:0]  in_tag_ff;

   logic               wk_vld_ff;
   logic [LOCK_W-1:0]  wk_lock_ff;
   logic [COUNT_W-1:0] wk_rc_ff;
   logic               wk_busy_ff;

   logic               rsp_vld_ff;
   status_type         rsp_status_ff;
   logic [LOCK_W-1:0]  rsp_lock_ff;
   logic [REQ_W-1:0]   rsp_tag_ff;
   logic               rsp_wr_ff;
   logic [COUNT_W-1:0] rsp_rc_ff;
   logic               rsp_busy_ff;
   logic               rsp_last_ff;

   logic [ENTRY_W-1:0] ram_rd_data;

   logic out_free, proc_fire, wk_fire, req_fire;

   logic [COUNT_W-1:0] cur_rc;
   logic               cur_busy;
   logic [HEAD_W-1:0]  cur_head;
   logic [FILL_W-1:0]  cur_fill;
   logic               bad_lock;

   logic [COUNT_W-1:0] rc_in;
   logic               busy_in;
   logic [HEAD_W-1:0]  head_in;
   logic [FILL_W-1:0]  fill_in;
   status_type         status_in;
   logic               wake;
   logic               enq_en;
   logic               enq_writer;
   logic [SUM_W-1:0]   tail_sum;
   logic [HEAD_W-1:0]  tail_pos;
   logic [HEAD_W-1:0]  head_next;
   logic [STORE_AW-1:0] wr_addr, rd_addr;

   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign proc_fire = in_vld_ff && !wk_vld_ff && out_free;
   assign wk_fire   = wk_vld_ff && out_free;
   assign req_chan.ready = !in_vld_ff || proc_fire;
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign cur_rc   = rc_ff[in_lock_ff];
   assign cur_busy = busy_ff[in_lock_ff];
   assign cur_head = head_ff[in_lock_ff];
   assign cur_fill = fill_ff[in_lock_ff];
   assign bad_lock = ({1'b0, in_lock_ff} >= locks_ff) || (32'(in_lock_ff) >= NUM_LOCKS);

   assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_fill);
   assign tail_pos  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
   assign head_next = (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   assign wr_addr   = STORE_AW'(in_lock_ff) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(tail_pos);
   assign rd_addr   = STORE_AW'(in_lock_ff) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(cur_head);

   always_comb begin
      logic want_wait;
      want_wait  = 1'b0;
      rc_in      = cur_rc;
      busy_in    = cur_busy;
      head_in    = cur_head;
      fill_in    = cur_fill;
      status_in  = ST_GRANTED;
      wake       = 1'b0;
      enq_writer = 1'b0;
      case (in_act_ff)
         ACT_RD_LOCK: begin
            if ((cur_busy && cur_rc == '0) || cur_rc[COUNT_W-1]) begin
               want_wait = 1'b1;
            end else begin
               rc_in = cur_rc + 1'b1;
               if (cur_rc == '0) begin
                  busy_in = 1'b1;
               end
            end
         end
         ACT_RD_UNLOCK: begin
            if (cur_rc == '0) begin
               status_in = ST_NOT_HELD;
            end else begin
               rc_in     = cur_rc - 1'b1;
               status_in = ST_RELEASED;
               if (cur_rc == COUNT_W'(1)) begin
                  busy_in = 1'b0;
                  wake    = cur_fill != '0;
               end
            end
         end
         ACT_WR_LOCK: begin
            enq_writer = 1'b1;
            if (cur_busy) begin
               want_wait = 1'b1;
            end else begin
               busy_in = 1'b1;
            end
         end
         default: begin
            if (!cur_busy || cur_rc != '0) begin
               status_in = ST_NOT_HELD;
            end else begin
               busy_in   = 1'b0;
               status_in = ST_RELEASED;
               wake      = cur_fill != '0;
            end
         end
      endcase
      enq_en = 1'b0;
      if (want_wait) begin
         if (32'(cur_fill) >= QUEUE_DEPTH) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_QUEUED;
            fill_in   = cur_fill + 1'b1;
            enq_en    = 1'b1;
         end
      end
      if (wake) begin
         head_in = head_next;
         fill_in = cur_fill - 1'b1;
      end
      if (bad_lock) begin
         status_in = ST_BAD_LOCK;
         enq_en    = 1'b0;
         wake      = 1'b0;
      end
   end

   rwlm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_waiters (
      .clock      (clock),
      .wr_en      (proc_fire && enq_en),
      .wr_addr    (wr_addr),
      .wr_data    ({enq_writer, in_tag_ff[TAG_BITS-1:0]}),
      .rd_en      (proc_fire && wake),
      .rd_addr    (rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         locks_ff   <= '0;
         in_vld_ff  <= 1'b0;
         wk_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            rc_ff[i]   <= '0;
            busy_ff[i] <= 1'b0;
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            locks_ff <= csr_wr_data;
         end
         if (req_fire) begin
            in_vld_ff <= 1'b1;
         end else if (proc_fire) begin
            in_vld_ff <= 1'b0;
         end
         if (proc_fire && !bad_lock) begin
            rc_ff[in_lock_ff]   <= rc_in;
            busy_ff[in_lock_ff] <= busy_in;
            head_ff[in_lock_ff] <= head_in;
            fill_ff[in_lock_ff] <= fill_in;
         end
         if (proc_fire) begin
            wk_vld_ff <= wake;
         end else if (wk_fire) begin
            wk_vld_ff <= 1'b0;
         end
         if (proc_fire || wk_fire) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_act_ff  <= action_type'(req_chan.action);
         in_lock_ff <= req_chan.lock_id;
         in_tag_ff  <= req_chan.requester;
      end
      if (proc_fire) begin
         wk_lock_ff <= in_lock_ff;
         wk_rc_ff   <= rc_in;
         wk_busy_ff <= busy_in;
         rsp_status_ff <= status_in;
         rsp_lock_ff   <= in_lock_ff;
         rsp_tag_ff    <= in_tag_ff;
         rsp_wr_ff     <= 1'b0;
         rsp_rc_ff     <= bad_lock ? '0 : rc_in;
         rsp_busy_ff   <= bad_lock ? 1'b0 : busy_in;
         rsp_last_ff   <= !wake;
      end else if (wk_fire) begin
         rsp_status_ff <= ST_WOKEN;
         rsp_lock_ff   <= wk_lock_ff;
         rsp_tag_ff    <= REQ_W'(ram_rd_data[TAG_BITS-1:0]);
         rsp_wr_ff     <= ram_rd_data[TAG_BITS];
         rsp_rc_ff     <= wk_rc_ff;
         rsp_busy_ff   <= wk_busy_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.result_lock      = rsp_lock_ff;
   assign rsp_chan.result_tag       = rsp_tag_ff;
   assign rsp_chan.waiter_is_writer = rsp_wr_ff;
   assign rsp_chan.readers_now      = rsp_rc_ff;
   assign rsp_chan.busy_now         = rsp_busy_ff;
   assign rsp_chan.last             = rsp_last_ff;

   // a non-final result is always a release whose waiter is still to follow
   a_first_has_partner: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_last_ff |-> wk_vld_ff)
      else $error("release without pending waiter");

   a_readers_imply_busy: assert property (@(posedge clock) disable iff (reset)
      proc_fire && !bad_lock && cur_rc != '0 |-> cur_busy)
      else $error("readers held while lock not busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      proc_fire && !bad_lock |-> 32'(cur_fill) <= QUEUE_DEPTH)
      else $error("wait queue overfilled");

   a_woken_follows: assert property (@(posedge clock) disable iff (reset)
      wk_fire |=> rsp_vld_ff && rsp_last_ff && rsp_status_ff == ST_WOKEN)
      else $error("woken waiter not presented");

endmodule

// ----- hdl/rwlm_ram.sv -----
module rwlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- sim/reader_writer_lock_manager_top_test.sv -----
module reader_writer_lock_manager_top_test import rwlm_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      action_type       act;
      logic [LOCK_W-1:0] id;
      logic [REQ_W-1:0]  tag;
   } lock_req_type;

   typedef struct packed {
      status_type          status;
      logic [LOCK_W-1:0]   lk;
      logic [REQ_W-1:0]    tag;
      logic                writer;
      logic [COUNT_W-1:0]  readers;
      logic                busy;
      logic                last;
   } lock_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   rwlm_req_if req_bus ();
   rwlm_rsp_if rsp_bus ();

   reader_writer_lock_manager_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #5 clock = ~clock;

   // mirror of the lock table
   logic [CFG_W-1:0]   lock_limit;
   logic [COUNT_W-1:0] reader_cnt [NUM_LOCKS];
   logic               lock_busy  [NUM_LOCKS];
   logic [ENTRY_W-1:0] wait_ring  [NUM_LOCKS][QUEUE_DEPTH];
   int                 wait_head  [NUM_LOCKS];
   int                 wait_fill  [NUM_LOCKS];

   lock_req_type     req_backlog [$];
   lock_outcome_type outcome_q [$];

   int  requests_queued   = 0;
   int  requests_accepted = 0;
   int  mismatches        = 0;
   int  send_gap          = 0;
   int  hold_left         = 0;
   int  long_holds_asked  = 0;
   int  long_holds_done   = 0;
   bit  src_idle_on       = 1'b0;
   bit  sink_idle_on      = 1'b0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic string show_outcome(input lock_outcome_type o);
      return $sformatf("st=%0d lock=%0d tag=%0d wr=%0d rd=%0d busy=%0d last=%0d",
                       o.status, o.lk, o.tag, o.writer, o.readers, o.busy, o.last);
   endfunction

   function automatic void add_outcome(input status_type st, input logic [LOCK_W-1:0] id,
                                       input logic [REQ_W-1:0] tag, input logic wr,
                                       input logic last);
      lock_outcome_type o;
      o.status  = st;
      o.lk      = id;
      o.tag     = tag;
      o.writer  = wr;
      o.readers = (st == ST_BAD_LOCK) ? '0 : reader_cnt[id];
      o.busy    = (st == ST_BAD_LOCK) ? 1'b0 : lock_busy[id];
      o.last    = last;
      outcome_q.push_back(o);
   endfunction

   function automatic status_type park_waiter(input int id, input logic [REQ_W-1:0] tag,
                                              input logic wr);
      int pos;
      if (wait_fill[id] >= QUEUE_DEPTH)
         return ST_FULL;
      pos = (wait_head[id] + wait_fill[id]) % QUEUE_DEPTH;
      wait_ring[id][pos] = {wr, tag[TAG_BITS-1:0]};
      wait_fill[id]++;
      return ST_QUEUED;
   endfunction

   function automatic void free_lock(input int id, input logic [REQ_W-1:0] tag);
      logic [ENTRY_W-1:0] e;
      if (wait_fill[id] == 0) begin
         add_outcome(ST_RELEASED, LOCK_W'(id), tag, 1'b0, 1'b1);
      end else begin
         e = wait_ring[id][wait_head[id]];
         wait_head[id] = (wait_head[id] + 1) % QUEUE_DEPTH;
         wait_fill[id]--;
         add_outcome(ST_RELEASED, LOCK_W'(id), tag, 1'b0, 1'b0);
         add_outcome(ST_WOKEN, LOCK_W'(id), REQ_W'(e[TAG_BITS-1:0]), e[TAG_BITS], 1'b1);
      end
   endfunction

   function automatic void resolve_request(input action_type act, input logic [LOCK_W-1:0] id,
                                           input logic [REQ_W-1:0] tag);
      status_type st;
      if (id >= lock_limit || id >= NUM_LOCKS) begin
         add_outcome(ST_BAD_LOCK, id, tag, 1'b0, 1'b1);
         return;
      end
      case (act)
         ACT_RD_LOCK: begin
            if ((lock_busy[id] && reader_cnt[id] == 0) || reader_cnt[id] >= 256) begin
               st = park_waiter(int'(id), tag, 1'b0);
            end else begin
               reader_cnt[id]++;
               if (reader_cnt[id] == 1)
                  lock_busy[id] = 1'b1;
               st = ST_GRANTED;
            end
         end
         ACT_RD_UNLOCK: begin
            if (reader_cnt[id] == 0) begin
               st = ST_NOT_HELD;
            end else begin
               reader_cnt[id]--;
               if (reader_cnt[id] != 0) begin
                  st = ST_RELEASED;
               end else begin
                  lock_busy[id] = 1'b0;
                  free_lock(int'(id), tag);
                  return;
               end
            end
         end
         ACT_WR_LOCK: begin
            if (lock_busy[id]) begin
               st = park_waiter(int'(id), tag, 1'b1);
            end else begin
               lock_busy[id] = 1'b1;
               st = ST_GRANTED;
            end
         end
         default: begin
            if (!lock_busy[id] || reader_cnt[id] != 0) begin
               st = ST_NOT_HELD;
            end else begin
               lock_busy[id] = 1'b0;
               free_lock(int'(id), tag);
               return;
            end
         end
      endcase
      add_outcome(st, id, tag, 1'b0, 1'b1);
   endfunction

   function automatic int pick_gap(input bit on);
      int r;
      if (!on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver, with prediction at acceptance
   always @(posedge clock) begin
      lock_req_type it;
      logic         nv;
      nv = req_bus.valid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            resolve_request(action_type'(req_bus.action), req_bus.lock_id, req_bus.requester);
            requests_accepted++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               it = req_backlog.pop_front();
               req_bus.action    <= it.act;
               req_bus.lock_id   <= it.id;
               req_bus.requester <= it.tag;
               nv = 1'b1;
               send_gap = pick_gap(src_idle_on);
            end
         end
      end
      req_bus.valid <= nv;
   end

   // result monitor and ready generation
   always @(posedge clock) begin
      lock_outcome_type got;
      lock_outcome_type exp;
      logic             nr;
      int               r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status  = status_type'(rsp_bus.status);
         got.lk      = rsp_bus.result_lock;
         got.tag     = rsp_bus.result_tag;
         got.writer  = rsp_bus.waiter_is_writer;
         got.readers = rsp_bus.readers_now;
         got.busy    = rsp_bus.busy_now;
         got.last    = rsp_bus.last;
         if (outcome_q.size() == 0) begin
            flag_mismatch({"unexpected result ", show_outcome(got)});
         end else begin
            exp = outcome_q.pop_front();
            if (got !== exp)
               flag_mismatch({"got ", show_outcome(got), " exp ", show_outcome(exp)});
         end
      end
      if (long_holds_asked != long_holds_done) begin
         hold_left = 400;
         long_holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         nr = 1'b0;
      end else if (!sink_idle_on) begin
         nr = 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            nr = 1'b1;
         end else if (r < 95) begin
            nr = 1'b0;
            hold_left = $urandom_range(0, 3);
         end else begin
            nr = 1'b0;
            hold_left = $urandom_range(10, 40);
         end
      end
      rsp_bus.ready <= nr;
   end

   task automatic queue_request(input action_type act, input int id, input int tag);
      lock_req_type it;
      it.act = act;
      it.id  = LOCK_W'(id);
      it.tag = REQ_W'(tag);
      req_backlog.push_back(it);
      requests_queued++;
   endtask

   task automatic drain();
      while (requests_accepted != requests_queued || outcome_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_lock_limit(input int v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lock_limit = CFG_W'(v);
      @(posedge clock);
   endtask

   // bursts on one lock with a random share of lock requests, plus stray requests
   task automatic add_random_requests(input int n);
      int id;
      int len;
      int lean;
      while (n > 0) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_request(action_type'($urandom_range(0, 3)), $urandom_range(0, NUM_LOCKS - 1),
                          $urandom_range(0, 255));
            n--;
         end else begin
            id   = $urandom_range(0, lock_limit - 1);
            len  = $urandom_range(2, 14);
            lean = $urandom_range(25, 85);
            repeat (len) begin
               if ($urandom_range(0, 99) < lean)
                  queue_request($urandom_range(0, 1) ? ACT_WR_LOCK : ACT_RD_LOCK, id,
                                $urandom_range(0, 255));
               else
                  queue_request($urandom_range(0, 1) ? ACT_WR_UNLOCK : ACT_RD_UNLOCK, id,
                                $urandom_range(0, 255));
               n--;
            end
         end
      end
   endtask

   initial begin
      #8_000_000;
      $display("FAIL reader_writer_lock_manager_top");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_RD_LOCK;
      req_bus.lock_id     = '0;
      req_bus.requester   = '0;
      rsp_bus.ready       = 1'b0;
      lock_limit          = '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
         reader_cnt[i] = '0;
         lock_busy[i]  = 1'b0;
         wait_head[i]  = 0;
         wait_fill[i]  = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // no locks created out of reset
      queue_request(ACT_RD_LOCK, 0, 0);
      queue_request(ACT_WR_UNLOCK, 15, 255);
      drain();
      set_lock_limit(0);
      queue_request(ACT_RD_UNLOCK, 0, 8'h80);
      drain();

      set_lock_limit(16);
      queue_request(ACT_RD_UNLOCK, 3, 8'h01);
      queue_request(ACT_WR_UNLOCK, 3, 8'h01);
      queue_request(ACT_WR_LOCK, 3, 8'h01);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         queue_request(i[0] ? ACT_WR_LOCK : ACT_RD_LOCK, 3, 8'h10 + i);
      queue_request(ACT_WR_LOCK, 3, 8'hAA);
      queue_request(ACT_WR_UNLOCK, 3, 8'h01);
      queue_request(ACT_RD_LOCK, 15, 8'hFF);
      queue_request(ACT_RD_LOCK, 15, 8'h7F);
      queue_request(ACT_WR_UNLOCK, 15, 8'hFF);
      queue_request(ACT_WR_LOCK, 15, 8'h5A);
      queue_request(ACT_RD_UNLOCK, 15, 8'hFF);
      queue_request(ACT_RD_UNLOCK, 15, 8'h7F);
      queue_request(ACT_RD_LOCK, 0, 8'h55);
      drain();

      // reader count saturation on one lock
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      for (int i = 0; i < 257; i++)
         queue_request(ACT_RD_LOCK, 7, $urandom_range(0, 255));
      queue_request(ACT_WR_LOCK, 7, $urandom_range(0, 255));
      for (int i = 0; i < 256; i++)
         queue_request(ACT_RD_UNLOCK, 7, $urandom_range(0, 255));
      drain();

      // long receiver stall with the sender flat out
      src_idle_on  = 1'b0;
      long_holds_asked++;
      add_random_requests(200);
      drain();

      src_idle_on = 1'b1;
      set_lock_limit(1);
      add_random_requests(150);
      drain();

      set_lock_limit(9);
      add_random_requests(150);
      drain();

      set_lock_limit(15);
      add_random_requests(80);
      drain();
      set_lock_limit(16);
      add_random_requests(80);
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0)
         $display("PASS reader_writer_lock_manager_top");
      else
         $display("FAIL reader_writer_lock_manager_top");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/rwlm_pkg.sv
hdl/rwlm_req_if.sv
hdl/rwlm_rsp_if.sv
hdl/rwlm_ram.sv
hdl/reader_writer_lock_manager_top.sv
sim/reader_writer_lock_manager_top_test.sv
